/* rtl/lru_page_replacement_macros.svh */
// assertion macros for the lru page replacement block
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication under reset
`define LRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under reset
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/lru_pkg.sv */
`timescale 1ns / 1ps

package lru_pkg;

    // fixed port widths
    localparam int PAGE_PORT_W  = 16;
    localparam int FAULT_W      = 16;
    localparam int RESIDENT_W   = 4;
    localparam int FRAME_CNT_W  = 4;

    localparam logic [FRAME_CNT_W-1:0] FRAME_COUNT_RESET = 4'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MISS,
        S_VCAP,
        S_SHRD,
        S_SHWR,
        S_INS
    } state_t;

    // result flags from the sequencer
    typedef struct packed {
        logic done;
        logic hit;
        logic victim_valid;
    } result_flags_t;

endpackage

/* rtl/lru_frame_mem.sv */
`timescale 1ns / 1ps

module lru_frame_mem
    import lru_pkg::*;
#(
    parameter int  MAX_FRAMES = 8,
    parameter int  PAGE_BITS  = 16,
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [PAGE_BITS-1:0] wdata,
    input  logic [IDX_W-1:0]     raddr,
    output logic [PAGE_BITS-1:0] rdata
);

    logic [PAGE_BITS-1:0] mem [MAX_FRAMES];
    logic [PAGE_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lru_ctrl.sv */
`timescale 1ns / 1ps

module lru_ctrl
    import lru_pkg::*;
#(
    parameter int  MAX_FRAMES = 8,
    parameter int  PAGE_BITS  = 16,
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int OCC_W      = $clog2(MAX_FRAMES + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [OCC_W-1:0]     capacity,
    output logic                 busy,
    output logic                 mem_we,
    output logic [IDX_W-1:0]     mem_waddr,
    output logic [PAGE_BITS-1:0] mem_wdata,
    output logic [IDX_W-1:0]     mem_raddr,
    input  logic [PAGE_BITS-1:0] mem_rdata,
    output result_flags_t        flags,
    output logic [PAGE_BITS-1:0] victim,
    output logic [FAULT_W-1:0]   faults,
    output logic [OCC_W-1:0]     occupancy
);

    state_t               state_reg, state_next;
    logic [OCC_W-1:0]     idx_reg, idx_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [PAGE_BITS-1:0] victim_reg, victim_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic                 hit_reg, hit_next;
    logic                 vvalid_reg, vvalid_next;
    logic                 done_reg, done_next;
    logic [OCC_W-1:0]     idx_plus;

    assign idx_plus = OCC_W'(idx_reg + 1'b1);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            occ_reg    <= '0;
            fault_reg  <= '0;
            hit_reg    <= 1'b0;
            vvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            occ_reg    <= occ_next;
            fault_reg  <= fault_next;
            hit_reg    <= hit_next;
            vvalid_reg <= vvalid_next;
            done_reg   <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        victim_reg <= victim_next;
    end

    // sequencer: scan, evict, close the gap, insert as most recent
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        occ_next    = occ_reg;
        page_next   = page_reg;
        victim_next = victim_reg;
        fault_next  = fault_reg;
        hit_next    = hit_reg;
        vvalid_next = vvalid_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[IDX_W-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    page_next   = page;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    vvalid_next = 1'b0;
                    victim_next = '0;
                    state_next  = (occ_reg != '0) ? S_READ : S_MISS;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (mem_rdata == page_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_SHRD;
                end
                else if (idx_plus < occ_reg)
                begin
                    idx_next   = idx_plus;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                if (fault_reg != '1)
                begin
                    fault_next = fault_reg + 1'b1;
                end
                if (occ_reg >= capacity)
                begin
                    mem_raddr   = '0;
                    idx_next    = '0;
                    vvalid_next = 1'b1;
                    state_next  = S_VCAP;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_VCAP:
            begin
                victim_next = mem_rdata;
                state_next  = S_SHRD;
            end
            S_SHRD:
            begin
                if (idx_plus < occ_reg)
                begin
                    mem_raddr  = idx_plus[IDX_W-1:0];
                    state_next = S_SHWR;
                end
                else
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_INS;
                end
            end
            S_SHWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_plus;
                state_next = S_SHRD;
            end
            S_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = occ_reg[IDX_W-1:0];
                mem_wdata  = page_reg;
                occ_next   = occ_reg + 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy               = (state_reg != S_IDLE);
    assign flags.done         = done_reg;
    assign flags.hit          = hit_reg;
    assign flags.victim_valid = vvalid_reg;
    assign victim             = victim_reg;
    assign faults             = fault_reg;
    assign occupancy          = occ_reg;

endmodule

/* rtl/lru_page_replacement.sv */
`timescale 1ns / 1ps

// LRU page replacement unit. Hold start with page_id until busy is low; the
// block then searches its resident pages one slot at a time with a single
// comparator, closes the gap left by the hit or evicted page one slot at a
// time, and writes the page as most recent. It takes no new page while busy
// is high; the frame memory has one registered read port. The result is
// shown for exactly one cycle with done high and cannot be stalled, so the
// receiver must take it in that cycle. frame_count may only be written while
// busy is low and no result is pending.
module lru_page_replacement
    import lru_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_PORT_W-1:0] page_id,
    input  logic                   frame_count_we,
    input  logic [FRAME_CNT_W-1:0] frame_count_wdata,
    output logic                   done,
    output logic                   hit,
    output logic                   victim_valid,
    output logic [PAGE_PORT_W-1:0] victim_page,
    output logic [FAULT_W-1:0]     fault_count,
    output logic [RESIDENT_W-1:0]  resident_count
);

    `include "lru_page_replacement_macros.svh"

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int OCC_W  = $clog2(MAX_FRAMES + 1);
    localparam int PW_W   = (PAGE_BITS > PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
    localparam int CAP_W  = (OCC_W > FRAME_CNT_W) ? OCC_W : FRAME_CNT_W;
    localparam int RES_XW = (OCC_W > RESIDENT_W) ? OCC_W : RESIDENT_W;

    logic [FRAME_CNT_W-1:0] frame_count_reg;
    logic [CAP_W-1:0]       fc_wide;
    logic [OCC_W-1:0]       capacity;
    logic [PW_W-1:0]        page_wide;
    logic [PAGE_BITS-1:0]   page_int;
    logic [PW_W-1:0]        victim_wide;
    logic [RES_XW-1:0]      occ_wide;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [PAGE_BITS-1:0]   mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [PAGE_BITS-1:0]   mem_rdata;
    result_flags_t          flags;
    logic [PAGE_BITS-1:0]   victim_int;
    logic [OCC_W-1:0]       occupancy;

    // frame count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (frame_count_we)
        begin
            frame_count_reg <= frame_count_wdata;
        end
    end

    // clamp the frame count to 1..MAX_FRAMES
    always_comb
    begin
        fc_wide = CAP_W'(frame_count_reg);
        if (fc_wide == '0)
        begin
            capacity = OCC_W'(1);
        end
        else if (fc_wide > CAP_W'(MAX_FRAMES))
        begin
            capacity = OCC_W'(MAX_FRAMES);
        end
        else
        begin
            capacity = fc_wide[OCC_W-1:0];
        end
    end

    // page width conversion
    assign page_wide = PW_W'(page_id);
    assign page_int  = page_wide[PAGE_BITS-1:0];

    lru_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .page      (page_int),
        .capacity  (capacity),
        .busy      (busy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .flags     (flags),
        .victim    (victim_int),
        .faults    (fault_count),
        .occupancy (occupancy)
    );

    lru_frame_mem #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result ports
    assign victim_wide    = PW_W'(victim_int);
    assign occ_wide       = RES_XW'(occupancy);
    assign done           = flags.done;
    assign hit            = flags.hit;
    assign victim_valid   = flags.victim_valid;
    assign victim_page    = victim_wide[PAGE_PORT_W-1:0];
    assign resident_count = occ_wide[RESIDENT_W-1:0];

    // checks
    `LRU_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "item did not raise busy")
    `LRU_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result shown while still busy")
    `LRU_ASSERT_NOW(a_hit_no_victim, clk, rst_n, done && hit, !victim_valid, "hit with eviction")
    `LRU_ASSERT_NOW(a_vzero, clk, rst_n, done && !victim_valid, victim_page == '0, "stray victim")
    `LRU_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occupancy <= OCC_W'(MAX_FRAMES), "too many pages")

endmodule
